// ----- hw/rtl/sls_pkg.sv -----
// Shared types and constants of the sorted linked-list store.
// Holds node index and link types, op and status codes, and the reset value of the next links.
// Depends on nothing; imported by sorted_linked_list_store.
package sls_pkg;

	localparam int CAPACITY  = 32;
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int VALUE_W   = 32;
	localparam int OP_W      = 2;
	localparam int STATUS_W  = 3;
	localparam int ENTRIES_W = 6;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [OP_W-1:0] op_t;
	typedef logic [STATUS_W-1:0] status_t;

	// A link is a node index with a flag that marks the end of a chain.
	typedef struct packed {
		logic none;
		idx_t idx;
	} link_t;

	localparam link_t LINK_NONE = '{none: 1'b1, idx: '0};

	localparam op_t OP_ADD     = 2'd0;
	localparam op_t OP_REMOVE  = 2'd1;
	localparam op_t OP_READOUT = 2'd2;

	localparam status_t ST_DONE      = 3'd0;
	localparam status_t ST_FULL      = 3'd1;
	localparam status_t ST_NOT_FOUND = 3'd2;
	localparam status_t ST_EMPTY     = 3'd3;
	localparam status_t ST_ELEMENT   = 3'd4;

	// After reset every node points to the one after it, which chains all
	// nodes into the free list; the last node ends the chain.
	function automatic link_t init_link(idx_t i);
		link_t l;
		if (int'(i) + 1 < CAPACITY) begin
			l = '{none: 1'b0, idx: IDX_W'(int'(i) + 1)};
		end else begin
			l = LINK_NONE;
		end
		return l;
	endfunction

endpackage

// ----- hw/rtl/sorted_linked_list_store.sv -----
// Top level of the sorted linked-list store: control sequencer and node memories.
// Depends on sls_pkg for types, codes and the reset value of the next links.
//
// The block keeps up to CAPACITY signed 32-bit values in ascending order as a
// doubly linked list of nodes held in three synchronous memories (values, next
// links, previous links). Unused nodes are chained on a free list.
//
// Input channel (in_valid/in_ready, fields op and value): one beat is one
// command. An add inserts the value in front of the first stored element that
// is not smaller, a remove unlinks the first equal element, a readout walks the
// list. Op code 3 is taken and dropped without a result.
// Output channel (out_valid/out_ready, fields status, item, is_last, entries):
// add and remove give one beat; a readout gives one beat per element, or one
// "list empty" beat, with is_last set on the final beat of the command.
//
// Commands are handled one at a time; in_ready is high only while idle. The
// walk reads one node per cycle from the memories (one read port, registered
// read data) while the output register can take a beat; the walk of an add
// or a remove never stalls. A readout gives one beat per cycle while the
// receiver takes them. An output register sits between the sequencer and
// the receiver: a stalled receiver only holds the sequencer when a new beat
// must be loaded, and the walk resumes as soon as the beat is taken.
// Reset empties the list and chains all nodes into the free list at once; the
// block comes out of reset idle, with in_ready high.
module sorted_linked_list_store (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  sls_pkg::op_t                        op,
	input  logic signed [sls_pkg::VALUE_W-1:0]  value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output sls_pkg::status_t                    status,
	output logic signed [sls_pkg::VALUE_W-1:0]  item,
	output logic                                is_last,
	output logic [sls_pkg::ENTRIES_W-1:0]       entries
);
	import sls_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD_POP,
		S_ADD_WALK,
		S_ADD_LINK,
		S_ADD_FIX,
		S_RM_WALK,
		S_RM_FREE,
		S_RD_WALK,
		S_DONE
	} state_t;

	state_t state_q;

	// Node memories. Values and previous links are only used for nodes that are
	// on the list, so they need no reset. Next links carry a written flag per
	// entry; an unwritten entry reads as its reset value.
	logic [VALUE_W-1:0] val_mem [CAPACITY];
	link_t              nl_mem  [CAPACITY];
	link_t              pl_mem  [CAPACITY];
	logic [CAPACITY-1:0] nl_vld_q;

	// Registered read data of the shared read address.
	logic [VALUE_W-1:0] val_rd_q;
	link_t              nl_mem_rd_q;
	link_t              pl_rd_q;
	logic               nl_vld_rd_q;
	idx_t               rd_addr_q;
	link_t              nl_rd;

	// Memory controls.
	logic  rd_en;
	idx_t  rd_addr;
	logic  val_we;
	logic  nl_we;
	idx_t  nl_waddr;
	link_t nl_wdata;
	logic  pl_we;
	idx_t  pl_waddr;
	link_t pl_wdata;

	// List state and work registers.
	link_t   first_q;
	link_t   free_q;
	cnt_t    count_q;
	logic signed [VALUE_W-1:0] v_q;
	idx_t    n_q;
	link_t   cur_q;
	link_t   prv_q;
	status_t res_q;

	// Output register.
	logic                      out_valid_q;
	status_t                   status_q;
	logic signed [VALUE_W-1:0] item_q;
	logic                      is_last_q;
	logic [ENTRIES_W-1:0]      entries_q;

	logic accept;
	logic full;
	logic slot_free;
	logic out_load;
	logic val_lt;
	logic val_eq;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign full      = (count_q >= CNT_W'(CAPACITY)) || free_q.none;
	assign slot_free = !out_valid_q || out_ready;
	// A new beat enters the output register in this cycle.
	assign out_load  = slot_free && (state_q == S_RD_WALK || state_q == S_DONE);
	assign nl_rd     = nl_vld_rd_q ? nl_mem_rd_q : init_link(rd_addr_q);
	assign val_lt    = $signed(val_rd_q) < v_q;
	assign val_eq    = $signed(val_rd_q) == v_q;

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign item      = item_q;
	assign is_last   = is_last_q;
	assign entries   = entries_q;

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[free_q.idx] <= value;
		end
		if (rd_en) begin
			val_rd_q <= val_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (nl_we) begin
			nl_mem[nl_waddr] <= nl_wdata;
		end
		if (rd_en) begin
			nl_mem_rd_q <= nl_mem[rd_addr];
			nl_vld_rd_q <= nl_vld_q[rd_addr];
			rd_addr_q   <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nl_vld_q <= '0;
		end else if (nl_we) begin
			nl_vld_q[nl_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pl_we) begin
			pl_mem[pl_waddr] <= pl_wdata;
		end
		if (rd_en) begin
			pl_rd_q <= pl_mem[rd_addr];
		end
	end

	// Memory accesses of each step. The only cycle that reads and writes the
	// same entry is the add that stores its value in the free head node while
	// fetching that node's links; the value read there is never used, so no
	// forwarding is needed.
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = first_q.idx;
		val_we   = 1'b0;
		nl_we    = 1'b0;
		nl_waddr = n_q;
		nl_wdata = LINK_NONE;
		pl_we    = 1'b0;
		pl_waddr = n_q;
		pl_wdata = LINK_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (op == OP_ADD) begin
						// Store the value in the free head node and fetch its
						// successor on the free list.
						val_we  = !full;
						rd_en   = !full;
						rd_addr = free_q.idx;
					end else if (op == OP_REMOVE || op == OP_READOUT) begin
						rd_en   = !first_q.none;
						rd_addr = first_q.idx;
					end
				end
			end
			S_ADD_POP: begin
				rd_en   = !first_q.none;
				rd_addr = first_q.idx;
			end
			S_ADD_WALK: begin
				rd_en   = val_lt && !nl_rd.none;
				rd_addr = nl_rd.idx;
			end
			S_ADD_LINK: begin
				nl_we    = 1'b1;
				nl_waddr = n_q;
				nl_wdata = cur_q;
				pl_we    = 1'b1;
				pl_waddr = n_q;
				pl_wdata = prv_q;
			end
			S_ADD_FIX: begin
				nl_we    = !prv_q.none;
				nl_waddr = prv_q.idx;
				nl_wdata = '{none: 1'b0, idx: n_q};
				pl_we    = !cur_q.none;
				pl_waddr = cur_q.idx;
				pl_wdata = '{none: 1'b0, idx: n_q};
			end
			S_RM_WALK: begin
				if (val_eq) begin
					// Unlink the matching node from both neighbors.
					nl_we    = !pl_rd_q.none;
					nl_waddr = pl_rd_q.idx;
					nl_wdata = nl_rd;
					pl_we    = !nl_rd.none;
					pl_waddr = nl_rd.idx;
					pl_wdata = pl_rd_q;
				end else begin
					rd_en   = !nl_rd.none;
					rd_addr = nl_rd.idx;
				end
			end
			S_RM_FREE: begin
				nl_we    = 1'b1;
				nl_waddr = n_q;
				nl_wdata = free_q;
			end
			S_RD_WALK: begin
				rd_en   = slot_free && !nl_rd.none;
				rd_addr = nl_rd.idx;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			first_q     <= LINK_NONE;
			free_q      <= '{none: 1'b0, idx: '0};
			count_q     <= '0;
			v_q         <= '0;
			n_q         <= '0;
			cur_q       <= LINK_NONE;
			prv_q       <= LINK_NONE;
			res_q       <= ST_DONE;
			out_valid_q <= 1'b0;
			status_q    <= ST_DONE;
			item_q      <= '0;
			is_last_q   <= 1'b0;
			entries_q   <= '0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						v_q <= value;
						case (op)
							OP_ADD: begin
								if (full) begin
									res_q   <= ST_FULL;
									state_q <= S_DONE;
								end else begin
									n_q     <= free_q.idx;
									state_q <= S_ADD_POP;
								end
							end
							OP_REMOVE: begin
								if (first_q.none) begin
									res_q   <= ST_NOT_FOUND;
									state_q <= S_DONE;
								end else begin
									state_q <= S_RM_WALK;
								end
							end
							OP_READOUT: begin
								if (first_q.none) begin
									res_q   <= ST_EMPTY;
									state_q <= S_DONE;
								end else begin
									state_q <= S_RD_WALK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_ADD_POP: begin
					free_q  <= nl_rd;
					prv_q   <= LINK_NONE;
					cur_q   <= first_q;
					state_q <= first_q.none ? S_ADD_LINK : S_ADD_WALK;
				end
				S_ADD_WALK: begin
					// Step past every element smaller than the new value.
					if (val_lt) begin
						prv_q <= '{none: 1'b0, idx: rd_addr_q};
						cur_q <= nl_rd;
						if (nl_rd.none) begin
							state_q <= S_ADD_LINK;
						end
					end else begin
						state_q <= S_ADD_LINK;
					end
				end
				S_ADD_LINK: begin
					state_q <= S_ADD_FIX;
				end
				S_ADD_FIX: begin
					if (prv_q.none) begin
						first_q <= '{none: 1'b0, idx: n_q};
					end
					count_q <= count_q + CNT_W'(1);
					res_q   <= ST_DONE;
					state_q <= S_DONE;
				end
				S_RM_WALK: begin
					if (val_eq) begin
						if (pl_rd_q.none) begin
							first_q <= nl_rd;
						end
						n_q     <= rd_addr_q;
						state_q <= S_RM_FREE;
					end else if (nl_rd.none) begin
						res_q   <= ST_NOT_FOUND;
						state_q <= S_DONE;
					end
				end
				S_RM_FREE: begin
					free_q  <= '{none: 1'b0, idx: n_q};
					count_q <= count_q - CNT_W'(1);
					res_q   <= ST_DONE;
					state_q <= S_DONE;
				end
				S_RD_WALK: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						status_q    <= ST_ELEMENT;
						item_q      <= val_rd_q;
						is_last_q   <= nl_rd.none;
						entries_q   <= ENTRIES_W'(count_q);
						if (nl_rd.none) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_DONE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						status_q    <= res_q;
						item_q      <= '0;
						is_last_q   <= 1'b1;
						entries_q   <= ENTRIES_W'(count_q);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
